/* hw/rtl/rvx_pkg.sv */
// ----------------------------------------------------------------------------
// Register VM execute package
// Shared constants, codes and types of the register VM execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvx_pkg;

   localparam int MEM_WORDS = 256;
   localparam int ADDR_W    = $clog2(MEM_WORDS);

   localparam logic [ADDR_W-1:0] W_R0 = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] W_PC = ADDR_W'(4);
   localparam logic [ADDR_W-1:0] W_SP = ADDR_W'(5);
   localparam logic [ADDR_W-1:0] W_BP = ADDR_W'(6);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_DIVZERO   = 2'd2,
      ST_MALFORMED = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,  OP_ADDI = 5'd1,  OP_SUB  = 5'd2,  OP_SUBI = 5'd3,
      OP_MUL  = 5'd4,  OP_MULI = 5'd5,  OP_DIV  = 5'd6,  OP_DIVI = 5'd7,
      OP_MOV  = 5'd8,  OP_MOVI = 5'd9,  OP_PUSH = 5'd10, OP_PUSHI = 5'd11,
      OP_POP  = 5'd12, OP_B    = 5'd13, OP_BEQ  = 5'd14, OP_BEQI = 5'd15,
      OP_BNE  = 5'd16, OP_BNEI = 5'd17, OP_BGE  = 5'd18, OP_BGEI = 5'd19,
      OP_BLEI = 5'd20, OP_RET  = 5'd21, OP_RETI = 5'd22, OP_HALT = 5'd23
   } func_type;

   typedef enum logic [1:0] {
      CSR_PROGRAM_LENGTH = 2'd0,
      CSR_STACK_BASE     = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_CFG_SP, S_CFG_BP, S_PC, S_INC, S_RDA, S_RDB,
      S_EVAL, S_DIV, S_DFIN, S_W1, S_W2, S_FIN0, S_FIN1, S_OUT
   } state_type;

   // True when a word value is a valid memory index.
   function automatic logic idx_ok(input logic [31:0] v);
      idx_ok = v < 32'(MEM_WORDS);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/rvx_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/register_vm_instruction_execute_unit.sv */
// ----------------------------------------------------------------------------
// Register VM instruction execute unit
// Executes one instruction per request transfer on a word memory whose low
// words serve as registers, and returns one response transfer per request.
// ----------------------------------------------------------------------------
// An instruction runs through S_PC, S_INC, S_RDA, S_RDB, S_EVAL, S_W1, S_W2,
// S_FIN0, S_FIN1 and S_OUT, with S_DIV and S_DFIN after S_EVAL for div and divi
// that pass the checks, because every access goes through the single port pair
// of the word memory and the quotient comes from a restoring divider that
// produces one bit per cycle. The unit takes one instruction at a time and
// holds req_stall high while it works. After reset a clearing pass over all
// MEM_WORDS words zeroes the memory and loads sp and bp with stack_base; a
// later write of stack_base makes the unit store sp and bp before it takes the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module register_vm_instruction_execute_unit
   import rvx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [4:0]  req_func,
   input  wire logic [31:0] req_dest,
   input  wire logic [31:0] req_arg1,
   input  wire logic [31:0] req_arg2,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_pc_after,
   output logic             rsp_finished,
   output logic [31:0]      rsp_return_value,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wr_data
);

   state_type state_ff, state_in;

   logic [15:0]       plen_ff;
   logic [7:0]        sbase_ff;
   logic              sb_pend_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   // Latched instruction.
   logic [4:0]  func_ff;
   logic [31:0] dest_ff, arg1_ff, arg2_ff;

   // Operands fetched from memory.
   logic [31:0] sp_ff, x_ff;

   // The second operand is taken straight from the read port in S_EVAL,
   // in the cycle after its address was presented in S_RDB.
   logic [31:0] y_rd;

   // Pending writes and status.
   status_type        st_ff;
   logic              w1_en_ff, w2_en_ff;
   logic [ADDR_W-1:0] w1_addr_ff, w2_addr_ff;
   logic [31:0]       w1_data_ff, w2_data_ff;
   logic              go_div_ff;
   logic [31:0]       r0_ff;

   // Divider.
   logic [31:0] div_rem_ff, div_quo_ff, div_den_ff;
   logic [4:0]  div_cnt_ff;
   logic        div_neg_ff;

   // Response register.
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_pc_ff, rsp_r0_ff;
   logic        rsp_fin_ff;

   // Memory ports.
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [31:0]       mem_wdata, mem_rdata;

   rvx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign y_rd = mem_rdata;

   logic req_xfer, out_free;
   assign req_stall = !(state_ff == S_IDLE && !sb_pend_ff);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Address of the first operand: the push source and ret read dest, blei
   // reads arg2, everything else reads arg1.
   logic [31:0] ia;
   always_comb begin
      case (func_ff) inside
         OP_PUSH, OP_RET: ia = dest_ff;
         OP_BLEI:         ia = arg2_ff;
         default:         ia = arg1_ff;
      endcase
   end

   // Evaluation of the fetched instruction.
   logic [31:0] imm, yv, alu_add, alu_sub, alu_mul, alu_res, push_v, sp_m1, cmp_y;
   logic [63:0] prod;
   logic        okd, oka, okb, oksp, tgt_ok, take;
   status_type  st_e;
   logic        w1_e, w2_e, div_e;
   logic [ADDR_W-1:0] w1_a, w2_a;
   logic [31:0] w1_d, w2_d;

   always_comb begin
      case (func_ff) inside
         OP_MOV:  imm = '0;
         OP_BLEI: imm = arg1_ff;
         default: imm = arg2_ff;
      endcase
      case (func_ff) inside
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: yv = y_rd;
         default:                        yv = imm;
      endcase
      okd     = idx_ok(dest_ff);
      oka     = idx_ok(ia);
      okb     = idx_ok(arg2_ff);
      oksp    = idx_ok(sp_ff);
      tgt_ok  = dest_ff < {16'd0, plen_ff};
      alu_add = x_ff + yv;
      alu_sub = x_ff - yv;
      prod    = x_ff * yv;
      alu_mul = prod[31:0];
      case (func_ff) inside
         OP_SUB, OP_SUBI: alu_res = alu_sub;
         OP_MUL, OP_MULI: alu_res = alu_mul;
         default:         alu_res = alu_add;
      endcase
      push_v = (func_ff == OP_PUSHI) ? dest_ff : x_ff;
      sp_m1  = sp_ff - 32'd1;
      case (func_ff) inside
         OP_BEQ, OP_BNE, OP_BGE: cmp_y = y_rd;
         default:                cmp_y = imm;
      endcase
      case (func_ff) inside
         OP_BEQ, OP_BEQI: take = x_ff == cmp_y;
         OP_BNE, OP_BNEI: take = x_ff != cmp_y;
         OP_B:            take = 1'b1;
         default:         take = $signed(x_ff) >= $signed(cmp_y);
      endcase

      st_e  = ST_OK;
      w1_e  = 1'b0;
      w2_e  = 1'b0;
      div_e = 1'b0;
      w1_a  = dest_ff[ADDR_W-1:0];
      w2_a  = dest_ff[ADDR_W-1:0];
      w1_d  = alu_res;
      w2_d  = '0;
      case (func_ff) inside
         OP_ADD, OP_SUB, OP_MUL: begin
            if (okd && oka && okb) w1_e = 1'b1;
            else st_e = ST_RANGE;
         end
         OP_DIV: begin
            if (!(okd && oka && okb)) st_e = ST_RANGE;
            else if (y_rd == '0) st_e = ST_DIVZERO;
            else div_e = 1'b1;
         end
         OP_ADDI, OP_SUBI, OP_MULI, OP_MOV: begin
            if (okd && oka) w1_e = 1'b1;
            else st_e = ST_RANGE;
         end
         OP_DIVI: begin
            if (arg2_ff == '0) st_e = ST_DIVZERO;
            else if (okd && oka) div_e = 1'b1;
            else st_e = ST_RANGE;
         end
         OP_MOVI: begin
            w1_d = arg1_ff;
            if (okd) w1_e = 1'b1;
            else st_e = ST_RANGE;
         end
         OP_PUSH, OP_PUSHI: begin
            // Store first, then bump the sp word as it stands after the store.
            w1_a = sp_ff[ADDR_W-1:0];
            w1_d = push_v;
            w2_a = W_SP;
            w2_d = ((sp_ff[ADDR_W-1:0] == W_SP) ? push_v : sp_ff) + 32'd1;
            if (oksp && (func_ff == OP_PUSHI || okd)) begin
               w1_e = 1'b1;
               w2_e = 1'b1;
            end else begin
               st_e = ST_RANGE;
            end
         end
         OP_POP: begin
            // Decrement sp first; the read sees the new sp if it is the sp word.
            w1_a = W_SP;
            w1_d = sp_m1;
            w2_d = (sp_m1[ADDR_W-1:0] == W_SP) ? sp_m1 : y_rd;
            if (okd && sp_ff != '0 && sp_ff <= 32'(MEM_WORDS)) begin
               w1_e = 1'b1;
               w2_e = 1'b1;
            end else begin
               st_e = ST_RANGE;
            end
         end
         OP_B, OP_BEQ, OP_BNE, OP_BGE, OP_BEQI, OP_BNEI, OP_BGEI, OP_BLEI: begin
            w1_a = W_PC;
            w1_d = dest_ff;
            if ((func_ff inside {OP_BEQ, OP_BNE, OP_BGE}) && !(oka && okb)) begin
               st_e = ST_RANGE;
            end else if (!(func_ff inside {OP_B, OP_BEQ, OP_BNE, OP_BGE}) && !oka) begin
               st_e = ST_RANGE;
            end else if (!tgt_ok) begin
               st_e = ST_RANGE;
            end else begin
               w1_e = take;
            end
         end
         OP_RET: begin
            w1_a = W_R0;
            w1_d = x_ff;
            if (okd) w1_e = 1'b1;
            else st_e = ST_RANGE;
         end
         OP_RETI: begin
            w1_a = W_R0;
            w1_d = dest_ff;
            w1_e = 1'b1;
         end
         OP_HALT: begin
            w1_a = W_PC;
            w1_d = {16'd0, plen_ff};
            w1_e = 1'b1;
         end
         default: st_e = ST_MALFORMED;
      endcase
   end

   // Divider step: shift one dividend bit into the remainder.
   logic [32:0] div_sh, div_diff;
   assign div_sh   = {div_rem_ff, div_quo_ff[31]};
   assign div_diff = div_sh - {1'b0, div_den_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR:    if (clr_cnt_ff == ADDR_W'(MEM_WORDS - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (sb_pend_ff) state_in = S_CFG_SP;
            else if (req_valid) state_in = S_PC;
         end
         S_CFG_SP: state_in = S_CFG_BP;
         S_CFG_BP: state_in = S_IDLE;
         S_PC:     state_in = S_INC;
         S_INC:    state_in = S_RDA;
         S_RDA:    state_in = S_RDB;
         S_RDB:    state_in = S_EVAL;
         S_EVAL:   state_in = div_e ? S_DIV : S_W1;
         S_DIV:    if (div_cnt_ff == 5'd31) state_in = S_DFIN;
         S_DFIN:   state_in = S_W1;
         S_W1:     state_in = S_W2;
         S_W2:     state_in = S_FIN0;
         S_FIN0:   state_in = S_FIN1;
         S_FIN1:   state_in = S_OUT;
         S_OUT:    if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Memory port control.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = W_PC;
      mem_wdata = mem_rdata + 32'd1;
      mem_raddr = W_PC;
      case (state_ff)
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = (clr_cnt_ff == W_SP || clr_cnt_ff == W_BP) ? {24'd0, sbase_ff} : '0;
         end
         S_CFG_SP: begin
            mem_we    = 1'b1;
            mem_waddr = W_SP;
            mem_wdata = {24'd0, sbase_ff};
         end
         S_CFG_BP: begin
            mem_we    = 1'b1;
            mem_waddr = W_BP;
            mem_wdata = {24'd0, sbase_ff};
         end
         S_INC: begin
            mem_we    = 1'b1;
            mem_raddr = W_SP;
         end
         S_RDA: mem_raddr = ia[ADDR_W-1:0];
         S_RDB: mem_raddr = (func_ff == OP_POP) ? sp_m1[ADDR_W-1:0] : arg2_ff[ADDR_W-1:0];
         S_W1: begin
            mem_we    = w1_en_ff;
            mem_waddr = w1_addr_ff;
            mem_wdata = w1_data_ff;
         end
         S_W2: begin
            mem_we    = w2_en_ff;
            mem_waddr = w2_addr_ff;
            mem_wdata = w2_data_ff;
         end
         S_FIN0: mem_raddr = W_R0;
         default: mem_raddr = W_PC;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         plen_ff      <= '0;
         sbase_ff     <= 8'd16;
         sb_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         if (csr_wr_en && csr_index == CSR_PROGRAM_LENGTH) plen_ff <= csr_wr_data;
         if (csr_wr_en && csr_index == CSR_STACK_BASE) begin
            sbase_ff   <= csr_wr_data[7:0];
            sb_pend_ff <= 1'b1;
         end else if (state_ff == S_CFG_BP) begin
            sb_pend_ff <= 1'b0;
         end
         if (state_ff == S_EVAL) div_cnt_ff <= '0;
         else if (state_ff == S_DIV) div_cnt_ff <= div_cnt_ff + 5'd1;
         if (state_ff == S_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff <= req_func;
         dest_ff <= req_dest;
         arg1_ff <= req_arg1;
         arg2_ff <= req_arg2;
      end
      case (state_ff)
         S_RDA: sp_ff <= mem_rdata;
         S_RDB: x_ff  <= mem_rdata;
         S_EVAL: begin
            st_ff      <= st_e;
            w1_en_ff   <= w1_e;
            w2_en_ff   <= w2_e;
            w1_addr_ff <= w1_a;
            w2_addr_ff <= w2_a;
            w1_data_ff <= w1_d;
            w2_data_ff <= w2_d;
            go_div_ff  <= div_e;
            div_rem_ff <= '0;
            div_quo_ff <= x_ff[31] ? -x_ff : x_ff;
            div_den_ff <= yv[31] ? -yv : yv;
            div_neg_ff <= x_ff[31] ^ yv[31];
         end
         S_DIV: begin
            if (!div_diff[32]) div_rem_ff <= div_diff[31:0];
            else div_rem_ff <= div_sh[31:0];
            div_quo_ff <= {div_quo_ff[30:0], !div_diff[32]};
         end
         S_DFIN: begin
            w1_en_ff   <= go_div_ff;
            w1_data_ff <= div_neg_ff ? -div_quo_ff : div_quo_ff;
         end
         S_FIN1: r0_ff <= mem_rdata;
         default: ;
      endcase
      if (state_ff == S_OUT && out_free) begin
         rsp_status_ff <= st_ff;
         rsp_pc_ff     <= mem_rdata;
         rsp_r0_ff     <= r0_ff;
         rsp_fin_ff    <= !mem_rdata[31] && (mem_rdata >= {16'd0, plen_ff});
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pc_after     = rsp_pc_ff;
   assign rsp_finished     = rsp_fin_ff;
   assign rsp_return_value = rsp_r0_ff;

endmodule

`default_nettype wire
